/* src/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge, off while reset is low
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every rising clock edge, also during reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/rmth_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmth_pkg
// shared constants, types and the heap order compare of the running median
// ----------------------------------------------------------------------------
package rmth_pkg;

    localparam int DEFAULT_HEAP_DEPTH   = 512;
    localparam int DEFAULT_SAMPLE_WIDTH = 16;

    // heap select: upper half is a min-heap, lower half a max-heap
    localparam logic HEAP_UPPER = 1'b0;
    localparam logic HEAP_LOWER = 1'b1;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_UP_RD  = 10'b00_0000_0010,
        ST_UP_CMP = 10'b00_0000_0100,
        ST_REBAL  = 10'b00_0000_1000,
        ST_POP_RD = 10'b00_0001_0000,
        ST_POP_LD = 10'b00_0010_0000,
        ST_DN_RDL = 10'b00_0100_0000,
        ST_DN_RDR = 10'b00_1000_0000,
        ST_DN_CMP = 10'b01_0000_0000,
        ST_FINISH = 10'b10_0000_0000
    } rmth_state_t;

    // true when a sits strictly above b in the order of the selected heap
    function automatic logic hp_better(input logic heap, input logic signed [31:0] a,
                                       input logic signed [31:0] b);
        logic res;
        if (heap == HEAP_LOWER)
        begin
            res = (a > b);
        end
        else
        begin
            res = (a < b);
        end
        return res;
    endfunction

endpackage

/* src/rmth_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmth_ram
// single-port synchronous ram, one write or read address per cycle,
// read data registered
// ----------------------------------------------------------------------------
module rmth_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* src/running_median_two_heaps_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_median_two_heaps_unit
// running median over a stream of signed samples kept in two binary heaps
// ----------------------------------------------------------------------------
// Each input item carries one signed sample; each produces one result item
// with twice the running median, the number of samples held and a rejected
// flag (set when 2*HEAP_DEPTH-1 samples are already held). The lower half of
// the samples lives in a max-heap and the upper half in a min-heap, each in
// its own single-port ram; heap tops are mirrored in registers. One item is
// worked at a time: a sift-up reads the parent, then compares and writes at
// each heap level, a sift-down reads the left child, then the right child,
// then compares and writes, since every level needs a ram read before the
// compare and write. A new item is taken as soon as the unit is idle; a
// finished item waits only while the previous result is still held in the
// output register. No clearing pass is needed after reset.
module running_median_two_heaps_unit
    import rmth_pkg::*;
#(
    parameter int HEAP_DEPTH   = DEFAULT_HEAP_DEPTH,
    parameter int SAMPLE_WIDTH = DEFAULT_SAMPLE_WIDTH,
    localparam int CW          = $clog2(2 * HEAP_DEPTH),
    localparam int IN_BYTES_W  = ((SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int OUT_BITS    = SAMPLE_WIDTH + 1 + CW,
    localparam int OUT_BYTES_W = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_BYTES_W-1:0]  s_axis_tdata,   // sample
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_BYTES_W-1:0] m_axis_tdata,   // median_doubled, held_count
    output logic                   m_axis_tuser    // rejected
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int AW   = $clog2(HEAP_DEPTH);
    localparam int SZ_W = $clog2(HEAP_DEPTH + 1);
    localparam int IW   = AW + 2;
    localparam int MW   = SW + 1;

    rmth_state_t state_reg, state_next;
    logic               heap_reg, heap_next;
    logic               second_reg, second_next;
    logic               rej_reg, rej_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic [SZ_W-1:0]    n_reg, n_next;
    logic [SZ_W-1:0]    usize_reg, usize_next;
    logic [SZ_W-1:0]    lsize_reg, lsize_next;
    logic signed [SW-1:0] val_reg, val_next;
    logic signed [SW-1:0] lval_reg, lval_next;
    logic signed [SW-1:0] pop_top_reg, pop_top_next;
    logic signed [SW-1:0] utop_reg, ltop_reg;
    logic               out_valid_reg, out_valid_next;
    logic signed [MW-1:0] out_med_reg, out_med_next;
    logic [CW-1:0]      out_cnt_reg, out_cnt_next;
    logic               out_rej_reg, out_rej_next;

    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    logic signed [SW-1:0] ram_wdata;
    logic [SW-1:0]      urdata, lrdata;
    logic signed [SW-1:0] rdata;

    logic signed [SW-1:0] x;
    logic [CW-1:0]      total, half;
    logic [AW-1:0]      par;
    logic [IW-1:0]      l_idx, r_idx, n_ext;
    logic               r_ok, pick_r, up_swap, dn_swap;
    logic signed [SW-1:0] best_val;
    logic [AW-1:0]      best_idx;
    logic signed [MW-1:0] uext, lext;

    rmth_ram #(.WIDTH(SW), .DEPTH(HEAP_DEPTH)) u_upper_ram (
        .clk   (clk),
        .we    (ram_we && (heap_reg == HEAP_UPPER)),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (urdata)
    );

    rmth_ram #(.WIDTH(SW), .DEPTH(HEAP_DEPTH)) u_lower_ram (
        .clk   (clk),
        .we    (ram_we && (heap_reg == HEAP_LOWER)),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (lrdata)
    );

    assign rdata    = (heap_reg == HEAP_LOWER) ? $signed(lrdata) : $signed(urdata);
    assign x        = $signed(s_axis_tdata[SW-1:0]);
    assign total    = CW'(usize_reg) + CW'(lsize_reg);
    assign half     = total >> 1;
    assign par      = (pos_reg - AW'(1)) >> 1;
    assign l_idx    = (IW'(pos_reg) << 1) | IW'(1);
    assign r_idx    = l_idx + IW'(1);
    assign n_ext    = IW'(n_reg);
    assign r_ok     = (r_idx < n_ext);
    assign up_swap  = hp_better(heap_reg, 32'(val_reg), 32'(rdata));
    assign pick_r   = r_ok && hp_better(heap_reg, 32'(rdata), 32'(lval_reg));
    assign best_val = pick_r ? rdata : lval_reg;
    assign best_idx = pick_r ? r_idx[AW-1:0] : l_idx[AW-1:0];
    assign dn_swap  = hp_better(heap_reg, 32'(best_val), 32'(val_reg));
    assign uext     = MW'(utop_reg);
    assign lext     = MW'(ltop_reg);

    // ram port: one access per cycle, hole-based sifting
    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = pos_reg;
        ram_wdata = val_reg;
        unique case (state_reg)
            ST_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    ram_we = 1'b1;
                end
                else
                begin
                    ram_addr = par;
                end
            end
            ST_UP_CMP:
            begin
                ram_we    = 1'b1;
                ram_wdata = up_swap ? rdata : val_reg;
            end
            ST_POP_RD:
            begin
                ram_addr = n_reg[AW-1:0];
            end
            ST_DN_RDL:
            begin
                if (l_idx >= n_ext)
                begin
                    ram_we = 1'b1;
                end
                else
                begin
                    ram_addr = l_idx[AW-1:0];
                end
            end
            ST_DN_RDR:
            begin
                ram_addr = r_idx[AW-1:0];
            end
            ST_DN_CMP:
            begin
                ram_we    = 1'b1;
                ram_wdata = dn_swap ? best_val : val_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        heap_next      = heap_reg;
        second_next    = second_reg;
        rej_next       = rej_reg;
        pos_next       = pos_reg;
        n_next         = n_reg;
        usize_next     = usize_reg;
        lsize_next     = lsize_reg;
        val_next       = val_reg;
        lval_next      = lval_reg;
        pop_top_next   = pop_top_reg;
        out_valid_next = out_valid_reg;
        out_med_next   = out_med_reg;
        out_cnt_next   = out_cnt_reg;
        out_rej_next   = out_rej_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    second_next = 1'b0;
                    val_next    = x;
                    if (total >= CW'(2 * HEAP_DEPTH - 1))
                    begin
                        rej_next   = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        rej_next   = 1'b0;
                        state_next = ST_UP_RD;
                        priority if (usize_reg != '0)
                        begin
                            heap_next = (x >= utop_reg) ? HEAP_UPPER : HEAP_LOWER;
                        end
                        else if (lsize_reg != '0)
                        begin
                            heap_next = (x <= ltop_reg) ? HEAP_LOWER : HEAP_UPPER;
                        end
                        else
                        begin
                            heap_next = HEAP_UPPER;
                        end
                        if (heap_next == HEAP_LOWER)
                        begin
                            pos_next   = lsize_reg[AW-1:0];
                            lsize_next = lsize_reg + SZ_W'(1);
                        end
                        else
                        begin
                            pos_next   = usize_reg[AW-1:0];
                            usize_next = usize_reg + SZ_W'(1);
                        end
                    end
                end
            end
            ST_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    state_next = second_reg ? ST_FINISH : ST_REBAL;
                end
                else
                begin
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP:
            begin
                if (up_swap)
                begin
                    pos_next   = par;
                    state_next = ST_UP_RD;
                end
                else
                begin
                    state_next = second_reg ? ST_FINISH : ST_REBAL;
                end
            end
            ST_REBAL:
            begin
                priority if (half != '0 && CW'(usize_reg) > half && CW'(lsize_reg) < half)
                begin
                    heap_next    = HEAP_UPPER;
                    pop_top_next = utop_reg;
                    usize_next   = usize_reg - SZ_W'(1);
                    n_next       = usize_reg - SZ_W'(1);
                    state_next   = ST_POP_RD;
                end
                else if (half != '0 && CW'(lsize_reg) > half && CW'(usize_reg) < half)
                begin
                    heap_next    = HEAP_LOWER;
                    pop_top_next = ltop_reg;
                    lsize_next   = lsize_reg - SZ_W'(1);
                    n_next       = lsize_reg - SZ_W'(1);
                    state_next   = ST_POP_RD;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_POP_RD:
            begin
                state_next = ST_POP_LD;
            end
            ST_POP_LD:
            begin
                // last entry fills the hole at the root
                val_next   = rdata;
                pos_next   = '0;
                state_next = ST_DN_RDL;
            end
            ST_DN_RDL:
            begin
                state_next = (l_idx >= n_ext) ? ST_IDLE : ST_DN_RDR;
                if (l_idx >= n_ext)
                begin
                    // sift-down done, insert the popped top into the other heap
                    second_next = 1'b1;
                    val_next    = pop_top_reg;
                    state_next  = ST_UP_RD;
                    if (heap_reg == HEAP_UPPER)
                    begin
                        heap_next  = HEAP_LOWER;
                        pos_next   = lsize_reg[AW-1:0];
                        lsize_next = lsize_reg + SZ_W'(1);
                    end
                    else
                    begin
                        heap_next  = HEAP_UPPER;
                        pos_next   = usize_reg[AW-1:0];
                        usize_next = usize_reg + SZ_W'(1);
                    end
                end
            end
            ST_DN_RDR:
            begin
                lval_next  = rdata;
                state_next = ST_DN_CMP;
            end
            ST_DN_CMP:
            begin
                if (dn_swap)
                begin
                    pos_next   = best_idx;
                    state_next = ST_DN_RDL;
                end
                else
                begin
                    second_next = 1'b1;
                    val_next    = pop_top_reg;
                    state_next  = ST_UP_RD;
                    if (heap_reg == HEAP_UPPER)
                    begin
                        heap_next  = HEAP_LOWER;
                        pos_next   = lsize_reg[AW-1:0];
                        lsize_next = lsize_reg + SZ_W'(1);
                    end
                    else
                    begin
                        heap_next  = HEAP_UPPER;
                        pos_next   = usize_reg[AW-1:0];
                        usize_next = usize_reg + SZ_W'(1);
                    end
                end
            end
            ST_FINISH:
            begin
                // wait here while the previous result is still held
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_cnt_next   = total;
                    out_rej_next   = rej_reg;
                    priority if (total == '0)
                    begin
                        out_med_next = '0;
                    end
                    else if (usize_reg > lsize_reg)
                    begin
                        out_med_next = uext <<< 1;
                    end
                    else if (lsize_reg > usize_reg)
                    begin
                        out_med_next = lext <<< 1;
                    end
                    else
                    begin
                        out_med_next = uext + lext;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            usize_reg     <= '0;
            lsize_reg     <= '0;
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
            rej_reg       <= 1'b0;
            heap_reg      <= HEAP_UPPER;
        end
        else
        begin
            state_reg     <= state_next;
            usize_reg     <= usize_next;
            lsize_reg     <= lsize_next;
            out_valid_reg <= out_valid_next;
            second_reg    <= second_next;
            rej_reg       <= rej_next;
            heap_reg      <= heap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        n_reg       <= n_next;
        val_reg     <= val_next;
        lval_reg    <= lval_next;
        pop_top_reg <= pop_top_next;
        out_med_reg <= out_med_next;
        out_cnt_reg <= out_cnt_next;
        out_rej_reg <= out_rej_next;
        // mirror every root write into the top registers
        if (ram_we && ram_addr == '0)
        begin
            if (heap_reg == HEAP_LOWER)
            begin
                ltop_reg <= ram_wdata;
            end
            else
            begin
                utop_reg <= ram_wdata;
            end
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_BYTES_W'({out_cnt_reg, out_med_reg});
    assign m_axis_tuser  = out_rej_reg;

endmodule

/* src/rmth_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmth_checker
// port-level checks on the running median unit, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rmth_checker
    import rmth_pkg::*;
#(
    parameter int HEAP_DEPTH   = DEFAULT_HEAP_DEPTH,
    parameter int SAMPLE_WIDTH = DEFAULT_SAMPLE_WIDTH,
    localparam int CW          = $clog2(2 * HEAP_DEPTH),
    localparam int IN_BYTES_W  = ((SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int OUT_BITS    = SAMPLE_WIDTH + 1 + CW,
    localparam int OUT_BYTES_W = ((OUT_BITS + 7) / 8) * 8
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [IN_BYTES_W-1:0]  s_axis_tdata,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_BYTES_W-1:0] m_axis_tdata,
    input logic                   m_axis_tuser
);

    localparam logic [CW-1:0] MAX_HELD = CW'(2 * HEAP_DEPTH - 1);

    logic [CW-1:0] held;
    logic          in_acc;

    assign held   = m_axis_tdata[SAMPLE_WIDTH+1 +: CW];
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // a pending result holds until taken
    `ASSERT_CLK(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result item dropped before taken")
    // one item at a time: no second item the cycle after an accept
    `ASSERT_CLK(a_one_at_a_time, in_acc |=> !s_axis_tready, "item accepted while busy")
    // the count never passes storage
    `ASSERT_CLK(a_held_range, m_axis_tvalid |-> held <= MAX_HELD, "held count out of range")
    // a rejected item reports full storage
    `ASSERT_CLK(a_rej_full, m_axis_tvalid && m_axis_tuser |-> held == MAX_HELD, "reject without full storage")

endmodule

bind running_median_two_heaps_unit rmth_checker #(
    .HEAP_DEPTH   (HEAP_DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_rmth_checker (.*);
